// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Helpers for the concurrent checks in the heap allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, constants and helpers for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

   localparam int MAX_EXTENTS    = 64;
   localparam int HEADER_BYTES   = 8;
   localparam int MIN_HEAP_BYTES = 5;
   localparam int CNT_W          = $clog2(MAX_EXTENTS + 1);
   localparam int IDX_W          = $clog2(MAX_EXTENTS);
   localparam int CSR_ADDR_W     = 4;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_INIT   = 2'd2,
      CMD_EXTEND = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NO_FIT      = 3'd1,
      ST_DOUBLE_FREE = 3'd2,
      ST_TABLE_FULL  = 3'd3,
      ST_HEAP_SMALL  = 3'd4
   } status_type;

   // Register indexes, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_HEAP_START = 2'd0,
      REG_HEAP_BYTES = 2'd1,
      REG_FIT_SLACK  = 2'd2,
      REG_UNUSED     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
   } extent_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [30:0] req_bytes;
      logic [31:0] addr;
      logic [31:0] block_bytes;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] user_addr;
      logic [31:0] granted_bytes;
   } rsp_type;

   typedef struct packed {
      logic [31:0] heap_start;
      logic [31:0] heap_bytes;
      logic [15:0] fit_slack;
   } cfg_type;

   // Control handed from the walker to the cell chain.
   typedef struct packed {
      logic       shift;
      extent_type tail;
   } chain_ctl_type;

   // Saturating 32-bit add.
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ffha_req_if.sv =====
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel of the heap allocator: valid/ready with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if import ffha_pkg::*; ();
   logic        valid;
   logic        ready;
   cmd_type     cmd;
   logic [30:0] req_bytes;
   logic [31:0] addr;
   logic [31:0] block_bytes;

   modport source (output valid, cmd, req_bytes, addr, block_bytes, input ready);
   modport sink   (input valid, cmd, req_bytes, addr, block_bytes, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ffha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel of the heap allocator: valid/ready with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_rsp_if import ffha_pkg::*; ();
   logic        valid;
   logic        ready;
   status_type  status;
   logic [31:0] user_addr;
   logic [31:0] granted_bytes;

   modport source (output valid, status, user_addr, granted_bytes, input ready);
   modport sink   (input valid, status, user_addr, granted_bytes, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-extent allocator with coalescing, built as a ring of cells.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (valid/ready) with cmd, req_bytes, addr and
// block_bytes; each request gives exactly one response on rsp_chan with
// status, user_addr and granted_bytes. Registers heap_start (0x0), heap_bytes
// (0x4) and fit_slack (0x8) sit on the APB-style csr_ port; the user writes
// them only while the block is idle, which the block itself does not enforce.
// The free-extent table lives in a ring of MAX_EXTENTS cells. Every request
// turns the ring once, one cell per cycle, and the head logic rewrites the
// entry leaving the ring. The response is loaded at the edge that ends the
// turn. The next request can be accepted once the walker is back in idle,
// so one request is worked on at a time. A new request is accepted while an
// earlier response still waits in the output register; if that response is
// still not taken when the next turn ends, the block holds its result and
// accepts nothing until it is taken.
// Reset empties the table (count zero) and loads fit_slack with 16.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator import ffha_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ffha_req_if.sink              req_chan,
   ffha_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff;
   req_type       req;
   rsp_type       rsp;
   chain_ctl_type ctl;
   extent_type    cell_q [MAX_EXTENTS];
   reg_index_type reg_idx;
   logic          csr_wr;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heap_start <= '0;
         cfg_ff.heap_bytes <= '0;
         cfg_ff.fit_slack  <= 16'd16;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_HEAP_START: cfg_ff.heap_start <= csr_pwdata;
            REG_HEAP_BYTES: cfg_ff.heap_bytes <= csr_pwdata;
            REG_FIT_SLACK:  cfg_ff.fit_slack  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_HEAP_START: csr_prdata = cfg_ff.heap_start;
         REG_HEAP_BYTES: csr_prdata = cfg_ff.heap_bytes;
         REG_FIT_SLACK:  csr_prdata = {16'd0, cfg_ff.fit_slack};
         default:        csr_prdata = '0;
      endcase
   end

   // Request and response payloads.
   assign req.cmd         = req_chan.cmd;
   assign req.req_bytes   = req_chan.req_bytes;
   assign req.addr        = req_chan.addr;
   assign req.block_bytes = req_chan.block_bytes;

   assign rsp_chan.status        = rsp.status;
   assign rsp_chan.user_addr     = rsp.user_addr;
   assign rsp_chan.granted_bytes = rsp.granted_bytes;

   // Ring of extent cells; the last one takes the rewritten head entry.
   for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_ring
      if (i == MAX_EXTENTS - 1) begin : g_tail
         ffha_cell u_cell (
            .clock    (clock),
            .shift_en (ctl.shift),
            .d        (ctl.tail),
            .q        (cell_q[i])
         );
      end else begin : g_mid
         ffha_cell u_cell (
            .clock    (clock),
            .shift_en (ctl.shift),
            .d        (cell_q[i+1]),
            .q        (cell_q[i])
         );
      end
   end

   ffha_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req       (req),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp       (rsp),
      .cfg       (cfg_ff),
      .e0        (cell_q[0]),
      .e1        (cell_q[1]),
      .ctl       (ctl)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ffha_cell.sv =====
// ----------------------------------------------------------------------------
// ffha_cell
// One slot of the extent ring; takes its neighbor's extent on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_cell import ffha_pkg::*; (
   input  logic       clock,
   input  logic       shift_en,
   input  extent_type d,
   output extent_type q
);

   extent_type slot_ff;

   // Payload only, so no reset is needed.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         slot_ff <= d;
      end
   end

   assign q = slot_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ffha_walker.sv =====
// ----------------------------------------------------------------------------
// ffha_walker
// Head of the extent ring: sequencer that rewrites the table in one turn.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ffha_walker import ffha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp,
   input  cfg_type       cfg,
   input  extent_type    e0,
   input  extent_type    e1,
   output chain_ctl_type ctl
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_WALK  = 3'b010,
      S_FLUSH = 3'b100
   } state_type;

   // How the output slot is filled while the ring turns.
   typedef enum logic [3:0] {
      M_COPY = 4'b0001,
      M_DOWN = 4'b0010,
      M_UP   = 4'b0100,
      M_REPL = 4'b1000
   } mode_type;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic [IDX_W-1:0] t_ff, t_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_next_ff, cnt_next_in;
   logic        done_ff, done_in;
   req_type     req_ff;
   extent_type  carry_ff, carry_in;
   status_type  status_ff, status_in;
   logic [31:0] ua_ff, ua_in, gr_ff, gr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept, last_t, v0, v1, pos0, here, full, tp, tn, tn0;
   logic [31:0] ins_start, ins_size, need, left;
   extent_type  out_e;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign last_t    = (t_ff == IDX_W'(MAX_EXTENTS - 1));
   assign v0        = (CNT_W'(t_ff) < cnt_ff);
   assign v1        = ((CNT_W'(t_ff) + CNT_W'(1)) < cnt_ff);
   assign full      = (cnt_ff >= CNT_W'(MAX_EXTENTS));

   // Extent to insert for free and extend.
   assign ins_start = (req_ff.cmd == CMD_FREE) ? (req_ff.addr - 32'(HEADER_BYTES))
                                               : req_ff.addr;
   assign ins_size  = (req_ff.cmd == CMD_FREE) ? req_ff.block_bytes
                                               : {1'b0, req_ff.req_bytes};
   assign need      = {1'b0, req_ff.req_bytes} + 32'(HEADER_BYTES);
   assign left      = e0.size - need;

   // Position tests: insert before the first entry, or right after e0.
   assign pos0 = (t_ff == '0) && (!v0 || (e0.start >= ins_start));
   assign here = v0 && (e0.start < ins_start) && (!v1 || (e1.start >= ins_start));
   assign tn0  = v0 && (({1'b0, ins_start} + {1'b0, ins_size}) == {1'b0, e0.start});
   assign tp   = (({1'b0, e0.start} + {1'b0, e0.size}) == {1'b0, ins_start});
   assign tn   = v1 && (({1'b0, ins_start} + {1'b0, ins_size}) == {1'b0, e1.start});

   // One step of the walk.
   always_comb begin
      mode_in     = mode_ff;
      carry_in    = carry_ff;
      done_in     = done_ff;
      status_in   = status_ff;
      ua_in       = ua_ff;
      gr_in       = gr_ff;
      cnt_next_in = cnt_next_ff;
      out_e       = e0;
      case (mode_ff)
         M_COPY: out_e = e0;
         M_DOWN: out_e = e1;
         M_UP: begin
            out_e    = carry_ff;
            carry_in = e0;
         end
         M_REPL: begin
            out_e   = carry_ff;
            mode_in = M_COPY;
         end
         default: out_e = e0;
      endcase
      if (!done_ff && (mode_ff == M_COPY)) begin
         case (req_ff.cmd)
            CMD_ALLOC: begin
               if (v0 && (e0.size >= need)) begin
                  done_in   = 1'b1;
                  status_in = ST_OK;
                  ua_in     = e0.start + 32'(HEADER_BYTES);
                  if ((left == '0) || (left < {16'd0, cfg.fit_slack})) begin
                     gr_in       = e0.size;
                     out_e       = e1;
                     mode_in     = M_DOWN;
                     cnt_next_in = cnt_ff - CNT_W'(1);
                  end else begin
                     gr_in       = need;
                     out_e.start = e0.start + need;
                     out_e.size  = left;
                  end
               end
            end
            CMD_INIT: begin
               done_in = 1'b1;
               if ((cfg.heap_bytes < 32'(MIN_HEAP_BYTES)) ||
                   (cfg.heap_bytes <= 32'(HEADER_BYTES))) begin
                  status_in = ST_HEAP_SMALL;
               end else begin
                  out_e.start = cfg.heap_start;
                  out_e.size  = cfg.heap_bytes - 32'(HEADER_BYTES);
                  cnt_next_in = CNT_W'(1);
               end
            end
            default: begin
               if (pos0) begin
                  done_in = 1'b1;
                  if (v0 && (e0.start == ins_start)) begin
                     status_in = ST_DOUBLE_FREE;
                  end else if (tn0) begin
                     out_e.start = ins_start;
                     out_e.size  = sat_add(ins_size, e0.size);
                  end else if (full) begin
                     status_in = ST_TABLE_FULL;
                  end else begin
                     out_e.start = ins_start;
                     out_e.size  = ins_size;
                     carry_in    = e0;
                     mode_in     = M_UP;
                     cnt_next_in = cnt_ff + CNT_W'(1);
                  end
               end else if (here) begin
                  done_in = 1'b1;
                  if (v1 && (e1.start == ins_start)) begin
                     status_in = ST_DOUBLE_FREE;
                  end else if (tp && tn) begin
                     out_e.size  = sat_add(sat_add(e0.size, ins_size), e1.size);
                     mode_in     = M_DOWN;
                     cnt_next_in = cnt_ff - CNT_W'(1);
                  end else if (tp) begin
                     out_e.size = sat_add(e0.size, ins_size);
                  end else if (tn) begin
                     carry_in.start = ins_start;
                     carry_in.size  = sat_add(ins_size, e1.size);
                     mode_in        = M_REPL;
                  end else if (full) begin
                     status_in = ST_TABLE_FULL;
                  end else begin
                     carry_in.start = ins_start;
                     carry_in.size  = ins_size;
                     mode_in        = M_UP;
                     cnt_next_in    = cnt_ff + CNT_W'(1);
                  end
               end
            end
         endcase
      end
   end

   assign ctl.shift = (state_ff == S_WALK);
   assign ctl.tail  = out_e;

   // Sequencer and response register.
   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_WALK;
               t_in     = '0;
            end
         end
         S_WALK: begin
            t_in = t_ff + IDX_W'(1);
            if (last_t) begin
               cnt_in = cnt_next_in;
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = status_in;
                  rsp_in.user_addr     = ua_in;
                  rsp_in.granted_bytes = gr_in;
                  state_in             = S_IDLE;
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.user_addr     = ua_ff;
               rsp_in.granted_bytes = gr_ff;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Per-request working registers.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      t_ff   <= t_in;
      if (accept) begin
         req_ff      <= req;
         mode_ff     <= M_COPY;
         cnt_next_ff <= cnt_ff;
         ua_ff       <= '0;
         gr_ff       <= '0;
         status_ff   <= (req.cmd == CMD_ALLOC) ? ST_NO_FIT : ST_OK;
         done_ff     <= ((req.cmd == CMD_FREE) && (req.addr == '0)) ||
                        ((req.cmd == CMD_EXTEND) && (req.req_bytes == '0));
      end else if (state_ff == S_WALK) begin
         mode_ff     <= mode_in;
         carry_ff    <= carry_in;
         done_ff     <= done_in;
         status_ff   <= status_in;
         ua_ff       <= ua_in;
         gr_ff       <= gr_in;
         cnt_next_ff <= cnt_next_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ASSERT_ALWAYS(a_count_range, clock, reset, cnt_ff <= CNT_W'(MAX_EXTENTS))
   `ASSERT_NEXT(a_walk_start, clock, reset, accept, (state_ff == S_WALK) && (t_ff == '0))
   `ASSERT_NEXT(a_walk_end, clock, reset, (state_ff == S_WALK) && last_t,
                state_ff != S_WALK)
   `ASSERT_NEXT(a_count_frozen, clock, reset, state_ff == S_IDLE && !accept,
                $stable(cnt_ff))

endmodule

`default_nettype wire
